>>> design/stt_pkg.sv
// ============================================================================
// stt_pkg: shared types and constants of the source text tokeniser
// Request and result payloads, scan modes, token kinds, character codes and
// the small helper functions used by the scanner.
// ============================================================================
package stt_pkg;

    // Counter widths of the offset and line trackers
    localparam int OFFSET_BITS = 16;
    localparam int LINE_BITS   = 16;

    // Widths of the result fields
    localparam int KIND_W  = 5;
    localparam int VALUE_W = 32;
    localparam int FIELD_W = 16;

    // Result queue depth and its fill counter width
    localparam int QUEUE_DEPTH = 4;
    localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);

    localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;
    localparam logic [LINE_BITS-1:0]   LINE_MAX   = '1;

    // Input request: one source byte
    typedef struct packed {
        logic [7:0] ch;
        logic       first;
    } stt_in_t;

    // One result token
    typedef struct packed {
        logic [KIND_W-1:0]  token_kind;
        logic [VALUE_W-1:0] number_value;
        logic [FIELD_W-1:0] start_offset;
        logic [FIELD_W-1:0] end_offset;
        logic [FIELD_W-1:0] token_line;
        logic               unterminated;
        logic               last;
    } stt_out_t;

    // Up to two tokens produced by one byte, in order
    typedef struct packed {
        logic [1:0] count;
        stt_out_t   res_a;
        stt_out_t   res_b;
    } stt_emit_t;

    // Pending scan mode
    typedef enum logic [3:0] {
        MODE_IDLE    = 4'd0,
        MODE_NUM     = 4'd1,
        MODE_IDENT   = 4'd2,
        MODE_STR     = 4'd3,
        MODE_BANG    = 4'd4,
        MODE_EQ      = 4'd5,
        MODE_LT      = 4'd6,
        MODE_GT      = 4'd7,
        MODE_SLASH   = 4'd8,
        MODE_COMMENT = 4'd9
    } mode_t;

    // Token kinds
    localparam logic [KIND_W-1:0] K_NUMBER   = 5'd0;
    localparam logic [KIND_W-1:0] K_IDENT    = 5'd1;
    localparam logic [KIND_W-1:0] K_STRING   = 5'd2;
    localparam logic [KIND_W-1:0] K_LPAREN   = 5'd3;
    localparam logic [KIND_W-1:0] K_RPAREN   = 5'd4;
    localparam logic [KIND_W-1:0] K_LBRACE   = 5'd5;
    localparam logic [KIND_W-1:0] K_RBRACE   = 5'd6;
    localparam logic [KIND_W-1:0] K_COMMA    = 5'd7;
    localparam logic [KIND_W-1:0] K_DOT      = 5'd8;
    localparam logic [KIND_W-1:0] K_MINUS    = 5'd9;
    localparam logic [KIND_W-1:0] K_PLUS     = 5'd10;
    localparam logic [KIND_W-1:0] K_SEMI     = 5'd11;
    localparam logic [KIND_W-1:0] K_STAR     = 5'd12;
    localparam logic [KIND_W-1:0] K_BANG     = 5'd13;
    localparam logic [KIND_W-1:0] K_BANG_EQ  = 5'd14;
    localparam logic [KIND_W-1:0] K_EQ       = 5'd15;
    localparam logic [KIND_W-1:0] K_EQ_EQ    = 5'd16;
    localparam logic [KIND_W-1:0] K_LESS     = 5'd17;
    localparam logic [KIND_W-1:0] K_LESS_EQ  = 5'd18;
    localparam logic [KIND_W-1:0] K_GREATER  = 5'd19;
    localparam logic [KIND_W-1:0] K_GREAT_EQ = 5'd20;
    localparam logic [KIND_W-1:0] K_SLASH    = 5'd21;
    localparam logic [KIND_W-1:0] K_END      = 5'd22;

    // Character codes
    localparam logic [7:0] CH_NUL        = 8'h00;
    localparam logic [7:0] CH_TAB        = 8'h09;
    localparam logic [7:0] CH_NEWLINE    = 8'h0A;
    localparam logic [7:0] CH_CR         = 8'h0D;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_BANG       = 8'h21;
    localparam logic [7:0] CH_QUOTE      = 8'h22;
    localparam logic [7:0] CH_LPAREN     = 8'h28;
    localparam logic [7:0] CH_RPAREN     = 8'h29;
    localparam logic [7:0] CH_STAR       = 8'h2A;
    localparam logic [7:0] CH_PLUS       = 8'h2B;
    localparam logic [7:0] CH_COMMA      = 8'h2C;
    localparam logic [7:0] CH_MINUS      = 8'h2D;
    localparam logic [7:0] CH_DOT        = 8'h2E;
    localparam logic [7:0] CH_SLASH      = 8'h2F;
    localparam logic [7:0] CH_ZERO       = 8'h30;
    localparam logic [7:0] CH_NINE       = 8'h39;
    localparam logic [7:0] CH_SEMI       = 8'h3B;
    localparam logic [7:0] CH_LESS       = 8'h3C;
    localparam logic [7:0] CH_EQUALS     = 8'h3D;
    localparam logic [7:0] CH_GREATER    = 8'h3E;
    localparam logic [7:0] CH_UPPER_A    = 8'h41;
    localparam logic [7:0] CH_UPPER_Z    = 8'h5A;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_LOWER_A    = 8'h61;
    localparam logic [7:0] CH_LOWER_Z    = 8'h7A;
    localparam logic [7:0] CH_LBRACE     = 8'h7B;
    localparam logic [7:0] CH_RBRACE     = 8'h7D;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z)) ||
               ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z));
    endfunction

    // Saturating increments
    function automatic logic [OFFSET_BITS-1:0] inc_off(input logic [OFFSET_BITS-1:0] v);
        return (v == OFFSET_MAX) ? v : v + 1'b1;
    endfunction

    function automatic logic [LINE_BITS-1:0] inc_line(input logic [LINE_BITS-1:0] v);
        return (v == LINE_MAX) ? v : v + 1'b1;
    endfunction

    // Kind of a one- or two-character comparison operator
    function automatic logic [KIND_W-1:0] op_kind(input mode_t m, input logic with_eq);
        logic [KIND_W-1:0] k;
        case (m)
            MODE_BANG: k = with_eq ? K_BANG_EQ  : K_BANG;
            MODE_EQ:   k = with_eq ? K_EQ_EQ    : K_EQ;
            MODE_LT:   k = with_eq ? K_LESS_EQ  : K_LESS;
            MODE_GT:   k = with_eq ? K_GREAT_EQ : K_GREATER;
            default:   k = K_END;
        endcase
        return k;
    endfunction

    // Build one token; last is set later by the scanner
    function automatic stt_out_t make_res(
        input logic [KIND_W-1:0]      kind,
        input logic [VALUE_W-1:0]     val,
        input logic [OFFSET_BITS-1:0] s,
        input logic [OFFSET_BITS-1:0] e,
        input logic [LINE_BITS-1:0]   ln,
        input logic                   unt
    );
        stt_out_t r;
        r.token_kind   = kind;
        r.number_value = val;
        r.start_offset = FIELD_W'(s);
        r.end_offset   = FIELD_W'(e);
        r.token_line   = FIELD_W'(ln);
        r.unterminated = unt;
        r.last         = 1'b0;
        return r;
    endfunction

endpackage

>>> design/stt_scanner.sv
// ============================================================================
// stt_scanner: per-byte scan state and token emission
// Holds the pending mode, number accumulator, token start and position and
// line counters; works out in one pass the up to two tokens a byte completes.
// ============================================================================
module stt_scanner
    import stt_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      step_en,
    input  stt_in_t   in_item,
    output stt_emit_t emit
);

    mode_t                  mode_reg,  mode_next;
    logic [VALUE_W-1:0]     acc_reg,   acc_next;
    logic [OFFSET_BITS-1:0] start_reg, start_next;
    logic [LINE_BITS-1:0]   sline_reg, sline_next;
    logic [OFFSET_BITS-1:0] pos_reg,   pos_next;
    logic [LINE_BITS-1:0]   line_reg,  line_next;
    logic                   fin_reg,   fin_next;

    mode_t                  eff_mode;
    logic [VALUE_W-1:0]     eff_acc;
    logic [OFFSET_BITS-1:0] eff_start;
    logic [LINE_BITS-1:0]   eff_sline;
    logic [OFFSET_BITS-1:0] eff_pos;
    logic [LINE_BITS-1:0]   eff_line;
    logic                   eff_fin;

    logic [7:0]  c;
    logic        fresh;
    logic        p_emit, f_emit;
    stt_out_t    p_res,  f_res;

    assign c = in_item.ch;

    // A first byte starts from the reset state
    always_comb begin
        if (in_item.first) begin
            eff_mode  = MODE_IDLE;
            eff_acc   = '0;
            eff_start = '0;
            eff_sline = '0;
            eff_pos   = '0;
            eff_line  = '0;
            eff_fin   = 1'b0;
        end else begin
            eff_mode  = mode_reg;
            eff_acc   = acc_reg;
            eff_start = start_reg;
            eff_sline = sline_reg;
            eff_pos   = pos_reg;
            eff_line  = line_reg;
            eff_fin   = fin_reg;
        end
    end

    // Scan step: close the pending token, then scan the byte afresh
    always_comb begin
        mode_next  = eff_mode;
        acc_next   = eff_acc;
        start_next = eff_start;
        sline_next = eff_sline;
        pos_next   = inc_off(eff_pos);
        line_next  = eff_line;
        fin_next   = eff_fin;
        fresh      = 1'b1;
        p_emit     = 1'b0;
        f_emit     = 1'b0;
        p_res      = make_res(K_END, '0, eff_start, eff_pos, eff_sline, 1'b0);
        f_res      = make_res(K_END, '0, eff_pos, inc_off(eff_pos), eff_line, 1'b0);

        if (!eff_fin) begin
            case (eff_mode)
                MODE_NUM: begin
                    if (is_digit(c)) begin
                        acc_next = (eff_acc << 3) + (eff_acc << 1)
                                 + VALUE_W'(c - CH_ZERO);
                        fresh    = 1'b0;
                    end else begin
                        p_emit = 1'b1;
                        p_res  = make_res(K_NUMBER, eff_acc, eff_start, eff_pos,
                                          eff_sline, 1'b0);
                    end
                end
                MODE_IDENT: begin
                    if (is_alpha(c) || (c == CH_UNDERSCORE)) begin
                        fresh = 1'b0;
                    end else begin
                        p_emit = 1'b1;
                        p_res  = make_res(K_IDENT, '0, eff_start, eff_pos,
                                          eff_sline, 1'b0);
                    end
                end
                MODE_STR: begin
                    fresh = 1'b0;
                    if (c == CH_QUOTE) begin
                        p_emit    = 1'b1;
                        p_res     = make_res(K_STRING, '0, eff_start, inc_off(eff_pos),
                                             eff_sline, 1'b0);
                        mode_next = MODE_IDLE;
                    end else if (c == CH_NUL) begin
                        // unterminated: flag it, the NUL then ends the source
                        p_emit = 1'b1;
                        p_res  = make_res(K_STRING, '0, eff_start, eff_pos,
                                          eff_sline, 1'b1);
                        fresh  = 1'b1;
                    end else if (c == CH_NEWLINE) begin
                        line_next = inc_line(eff_line);
                    end
                end
                MODE_BANG, MODE_EQ, MODE_LT, MODE_GT: begin
                    p_emit = 1'b1;
                    if (c == CH_EQUALS) begin
                        p_res     = make_res(op_kind(eff_mode, 1'b1), '0, eff_start,
                                             inc_off(eff_pos), eff_sline, 1'b0);
                        mode_next = MODE_IDLE;
                        fresh     = 1'b0;
                    end else begin
                        p_res = make_res(op_kind(eff_mode, 1'b0), '0, eff_start,
                                         eff_pos, eff_sline, 1'b0);
                    end
                end
                MODE_SLASH: begin
                    if (c == CH_SLASH) begin
                        mode_next = MODE_COMMENT;
                        fresh     = 1'b0;
                    end else begin
                        p_emit = 1'b1;
                        p_res  = make_res(K_SLASH, '0, eff_start, eff_pos,
                                          eff_sline, 1'b0);
                    end
                end
                MODE_COMMENT: begin
                    if ((c != CH_NEWLINE) && (c != CH_NUL)) begin
                        fresh = 1'b0;
                    end
                end
                default: begin
                end
            endcase

            // Fresh scan of this byte
            if (fresh) begin
                mode_next = MODE_IDLE;
                if (is_digit(c)) begin
                    mode_next  = MODE_NUM;
                    start_next = eff_pos;
                    sline_next = eff_line;
                    acc_next   = VALUE_W'(c - CH_ZERO);
                end else if (is_alpha(c)) begin
                    mode_next  = MODE_IDENT;
                    start_next = eff_pos;
                    sline_next = eff_line;
                end else begin
                    case (c)
                        CH_LPAREN: begin f_emit = 1'b1; f_res.token_kind = K_LPAREN; end
                        CH_RPAREN: begin f_emit = 1'b1; f_res.token_kind = K_RPAREN; end
                        CH_LBRACE: begin f_emit = 1'b1; f_res.token_kind = K_LBRACE; end
                        CH_RBRACE: begin f_emit = 1'b1; f_res.token_kind = K_RBRACE; end
                        CH_COMMA:  begin f_emit = 1'b1; f_res.token_kind = K_COMMA;  end
                        CH_DOT:    begin f_emit = 1'b1; f_res.token_kind = K_DOT;    end
                        CH_MINUS:  begin f_emit = 1'b1; f_res.token_kind = K_MINUS;  end
                        CH_PLUS:   begin f_emit = 1'b1; f_res.token_kind = K_PLUS;   end
                        CH_SEMI:   begin f_emit = 1'b1; f_res.token_kind = K_SEMI;   end
                        CH_STAR:   begin f_emit = 1'b1; f_res.token_kind = K_STAR;   end
                        CH_BANG, CH_EQUALS, CH_LESS, CH_GREATER, CH_SLASH,
                        CH_QUOTE: begin
                            start_next = eff_pos;
                            sline_next = eff_line;
                            case (c)
                                CH_BANG:    mode_next = MODE_BANG;
                                CH_EQUALS:  mode_next = MODE_EQ;
                                CH_LESS:    mode_next = MODE_LT;
                                CH_GREATER: mode_next = MODE_GT;
                                CH_SLASH:   mode_next = MODE_SLASH;
                                default:    mode_next = MODE_STR;
                            endcase
                        end
                        CH_SPACE, CH_CR, CH_TAB: begin
                        end
                        CH_NEWLINE: begin
                            line_next = inc_line(eff_line);
                        end
                        default: begin
                            // NUL or unrecognised byte ends the source
                            f_emit   = 1'b1;
                            fin_next = 1'b1;
                        end
                    endcase
                end
            end
        end
    end

    // Order the tokens and mark the final one
    always_comb begin
        emit.count = {1'b0, p_emit} + {1'b0, f_emit};
        emit.res_a = p_emit ? p_res : f_res;
        emit.res_b = f_res;
        if (p_emit && f_emit) begin
            emit.res_b.last = 1'b1;
        end else begin
            emit.res_a.last = 1'b1;
        end
    end

    // Scan state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_IDLE;
            acc_reg   <= '0;
            start_reg <= '0;
            sline_reg <= '0;
            pos_reg   <= '0;
            line_reg  <= '0;
            fin_reg   <= 1'b0;
        end else if (step_en) begin
            mode_reg  <= mode_next;
            acc_reg   <= acc_next;
            start_reg <= start_next;
            sline_reg <= sline_next;
            pos_reg   <= pos_next;
            line_reg  <= line_next;
            fin_reg   <= fin_next;
        end
    end

endmodule

>>> design/stt_result_queue.sv
// ============================================================================
// stt_result_queue: result queue with registered head
// Shift queue taking up to two tokens per cycle and handing out one; the
// head entry drives the result channel directly.
// ============================================================================
module stt_result_queue
    import stt_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  stt_emit_t push_data,
    input  logic      pop,
    output logic      room,
    output logic      head_valid,
    output stt_out_t  head
);

    stt_out_t             entry_reg [QUEUE_DEPTH];
    stt_out_t             entry_next [QUEUE_DEPTH];
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [COUNT_W-1:0]   base;
    logic [COUNT_W-1:0]   add;

    assign head_valid = (count_reg != '0);
    assign head       = entry_reg[0];

    // Occupancy after this cycle's pop
    assign base = count_reg - COUNT_W'(pop);
    assign room = (base <= COUNT_W'(QUEUE_DEPTH - 2));
    assign add  = push ? COUNT_W'(push_data.count) : '0;

    assign count_next = base + add;

    // Shift down on pop, then write new tokens behind the survivors
    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (pop && (i < QUEUE_DEPTH - 1)) begin
                entry_next[i] = entry_reg[(i + 1) % QUEUE_DEPTH];
            end else begin
                entry_next[i] = entry_reg[i];
            end
            if ((add != '0) && (base == COUNT_W'(i))) begin
                entry_next[i] = push_data.res_a;
            end
            if ((add == COUNT_W'(2)) && ((base + 1'b1) == COUNT_W'(i))) begin
                entry_next[i] = push_data.res_b;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            entry_reg[i] <= entry_next[i];
        end
    end

endmodule

>>> design/source_text_tokenizer.sv
// ============================================================================
// source_text_tokenizer: streaming lexical scanner top level
// Input register, single-pass scanner and result queue.
// ============================================================================
// The first token of an accepted byte passes through the input register, then
// the scan into the queue head, which waits while the queue lacks room.
// Throughput: one byte per cycle while the four-entry result queue has room
// for two tokens; result draining (one token per cycle) bounds bursts.
// Reset: aresetn synchronous, active low; clears scan state, position, line,
// input register and queue.
module source_text_tokenizer
    import stt_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  stt_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output stt_out_t m_data
);

    stt_in_t   in_reg;
    logic      in_valid_reg;
    logic      step_en;
    logic      room;
    stt_emit_t emit;

    // Scan the held byte once the queue can take its tokens
    assign step_en = in_valid_reg && room;
    assign s_ready = !in_valid_reg || step_en;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
    end

    stt_scanner u_scanner (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (step_en),
        .in_item (in_reg),
        .emit    (emit)
    );

    stt_result_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (step_en),
        .push_data  (emit),
        .pop        (m_valid && m_ready),
        .room       (room),
        .head_valid (m_valid),
        .head       (m_data)
    );

endmodule
